// ----- design/cbm_pkg.sv -----
package cbm_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int ROM_OFF_W   = 21;
    localparam int RAM_OFF_W   = 15;
    localparam int ROM_BANK_W  = 7;
    localparam int RAM_BANK_W  = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int CTYPE_W     = 2;
    localparam int BANK_CNT_W  = 3;

    // byte offset bits inside one bank
    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int ROM_IN_BANK_W  = $clog2(ROM_BANK_BYTES);
    localparam int RAM_IN_BANK_W  = $clog2(RAM_BANK_BYTES);

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_CTRL_TYPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANKS = 2'd1;

    // controller codes
    localparam logic [CTYPE_W-1:0] CTRL_NONE = 2'd0;
    localparam logic [CTYPE_W-1:0] CTRL_MBC1 = 2'd1;
    localparam logic [CTYPE_W-1:0] CTRL_MBC2 = 2'd2;

    // access codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // result target codes
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_ROM  = 2'd1;
    localparam logic [1:0] TGT_RAM  = 2'd2;

    // register window select, address bits 14:13 below 0x8000
    localparam logic [1:0] WIN_RAM_EN   = 2'd0;
    localparam logic [1:0] WIN_ROM_LOW  = 2'd1;
    localparam logic [1:0] WIN_ROM_HIGH = 2'd2;
    localparam logic [1:0] WIN_MODE     = 2'd3;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    typedef struct packed {
        logic                  opcode;
        logic [ADDR_W-1:0]     bus_address;
        logic [DATA_W-1:0]     write_value;
    } req_t;

    typedef struct packed {
        logic [1:0]            target;
        logic [ROM_OFF_W-1:0]  rom_offset;
        logic [RAM_OFF_W-1:0]  ram_offset;
        logic                  ram_allowed;
        logic [ROM_BANK_W-1:0] rom_bank_now;
        logic [RAM_BANK_W-1:0] ram_bank_now;
    } rsp_t;

endpackage

// ----- design/cartridge_bank_mapper_top.sv -----
// cartridge bank mapper: mbc1 / mbc2 style bank controller for cpu bus accesses
//
// req channel (req_valid / req_ready / req): one bus access per transfer.
//   writes below 0x8000 update the bank registers, reads of 0x0000-0x7fff
//   give a rom byte offset, accesses to 0xa000-0xbfff give a ram byte offset
// rsp channel (rsp_valid / rsp_ready / rsp): exactly one result per access,
//   in order, carrying target, offsets, ram_allowed and the banks after it
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is the
//   controller type, index 1 the ram bank count; cfg_ready is always high,
//   write only while no access is in flight
// path: an accepted access passes the input register, then the result register,
//   which is presented on rsp
// throughput: one access per cycle, back to back, with no bubbles, while rsp_ready is high
// stall: when rsp_ready is low the result register holds, the input register
//   still fills once, then req_ready drops until the result is taken
// reset: rom bank 1, ram bank 0, ram disabled, rom banking mode, controller
//   type none, no ram banks, both pipeline stages empty
module cartridge_bank_mapper_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  cbm_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output cbm_pkg::rsp_t                       rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration registers
    logic [cbm_pkg::CTYPE_W-1:0]    ctype_reg;
    logic [cbm_pkg::BANK_CNT_W-1:0] bank_cnt_reg;

    // controller state
    logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [cbm_pkg::RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic                           ram_en_reg, ram_en_next;
    logic                           rom_mode_reg, rom_mode_next;

    // pipeline registers
    cbm_pkg::req_t s1_reg;
    logic          s1_valid_reg;
    cbm_pkg::rsp_t rsp_reg, rsp_next;
    logic          rsp_valid_reg;

    logic out_free;
    logic s1_fire;
    logic req_fire;

    logic                           is_mbc1;
    logic                           is_mbc2;
    logic                           reg_write;
    logic [cbm_pkg::ROM_BANK_W-1:0] bank_raw;
    logic                           bank_load;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_mbc1   = (ctype_reg == cbm_pkg::CTRL_MBC1);
    assign is_mbc2   = (ctype_reg == cbm_pkg::CTRL_MBC2);
    assign reg_write = (s1_reg.opcode == cbm_pkg::OP_WRITE) && !s1_reg.bus_address[15];

    // register writes from the access sitting in the input register
    always_comb
    begin
        ram_en_next   = ram_en_reg;
        ram_bank_next = ram_bank_reg;
        rom_mode_next = rom_mode_reg;
        bank_raw      = rom_bank_reg;
        bank_load     = 1'b0;
        if (reg_write)
        begin
            case (s1_reg.bus_address[14:13])
                cbm_pkg::WIN_RAM_EN:
                begin
                    if (is_mbc1 || (is_mbc2 && !s1_reg.bus_address[4]))
                    begin
                        ram_en_next = (s1_reg.write_value[3:0] == cbm_pkg::RAM_EN_KEY);
                    end
                end
                cbm_pkg::WIN_ROM_LOW:
                begin
                    if (is_mbc1)
                    begin
                        bank_raw  = {rom_bank_reg[6:5], s1_reg.write_value[4:0]};
                        bank_load = 1'b1;
                    end
                    else if (is_mbc2)
                    begin
                        bank_raw  = {3'b000, s1_reg.write_value[3:0]};
                        bank_load = 1'b1;
                    end
                end
                cbm_pkg::WIN_ROM_HIGH:
                begin
                    if (is_mbc1)
                    begin
                        if (rom_mode_reg)
                        begin
                            bank_raw  = {s1_reg.write_value[1:0], rom_bank_reg[4:0]};
                            bank_load = 1'b1;
                        end
                        else
                        begin
                            ram_bank_next = s1_reg.write_value[1:0];
                        end
                    end
                end
                cbm_pkg::WIN_MODE:
                begin
                    if (is_mbc1)
                    begin
                        rom_mode_next = !s1_reg.write_value[0];
                        if (!s1_reg.write_value[0])
                        begin
                            ram_bank_next = '0;
                        end
                    end
                end
                default:
                begin
                    bank_load = 1'b0;
                end
            endcase
        end
        // bank zero maps to bank one
        if (bank_load && (bank_raw == '0))
        begin
            rom_bank_next = {{(cbm_pkg::ROM_BANK_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            rom_bank_next = bank_raw;
        end
    end

    // address translation uses the banks as they stood before the access;
    // reads never change them, so old and new agree where it matters
    always_comb
    begin
        rsp_next.target      = cbm_pkg::TGT_NONE;
        rsp_next.rom_offset  = '0;
        rsp_next.ram_offset  = '0;
        rsp_next.ram_allowed = ram_en_next && (bank_cnt_reg != '0);
        rsp_next.rom_bank_now = rom_bank_next;
        rsp_next.ram_bank_now = ram_bank_next;
        if (!s1_reg.bus_address[15])
        begin
            if (s1_reg.opcode == cbm_pkg::OP_READ)
            begin
                rsp_next.target = cbm_pkg::TGT_ROM;
                if (!s1_reg.bus_address[14])
                begin
                    // fixed bank 0
                    rsp_next.rom_offset = {{cbm_pkg::ROM_BANK_W{1'b0}},
                                           s1_reg.bus_address[cbm_pkg::ROM_IN_BANK_W-1:0]};
                end
                else
                begin
                    rsp_next.rom_offset = {rom_bank_reg,
                                           s1_reg.bus_address[cbm_pkg::ROM_IN_BANK_W-1:0]};
                end
            end
        end
        else if (s1_reg.bus_address[15:13] == 3'b101)
        begin
            // external ram window 0xa000-0xbfff, reads and writes alike
            rsp_next.target     = cbm_pkg::TGT_RAM;
            rsp_next.ram_offset = {ram_bank_reg,
                                   s1_reg.bus_address[cbm_pkg::RAM_IN_BANK_W-1:0]};
        end
    end

    // configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctype_reg    <= cbm_pkg::CTRL_NONE;
            bank_cnt_reg <= '0;
            rom_bank_reg <= {{(cbm_pkg::ROM_BANK_W-1){1'b0}}, 1'b1};
            ram_bank_reg <= '0;
            ram_en_reg   <= 1'b0;
            rom_mode_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == cbm_pkg::CFG_CTRL_TYPE)
                begin
                    ctype_reg <= cfg_data[cbm_pkg::CTYPE_W-1:0];
                end
                else if (cfg_index == cbm_pkg::CFG_RAM_BANKS)
                begin
                    bank_cnt_reg <= cfg_data[cbm_pkg::BANK_CNT_W-1:0];
                end
            end
            if (s1_fire)
            begin
                rom_bank_reg <= rom_bank_next;
                ram_bank_reg <= ram_bank_next;
                ram_en_reg   <= ram_en_next;
                rom_mode_reg <= rom_mode_next;
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_reg <= req;
        end
        if (s1_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTH
    // the switchable rom bank never reads as zero
    a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rom_bank_reg != '0)
        else $error("rom bank register holds zero");

    // bank state only moves when an access leaves the input register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(rom_bank_reg) && $stable(ram_bank_reg)
                     && $stable(ram_en_reg) && $stable(rom_mode_reg))
        else $error("bank state changed with no access retiring");

    // with no controller selected nothing can be switched
    a_no_ctrl_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (ctype_reg != cbm_pkg::CTRL_MBC1 && ctype_reg != cbm_pkg::CTRL_MBC2)
        |=> $stable(rom_bank_reg) && $stable(ram_bank_reg) && $stable(ram_en_reg))
        else $error("bank state changed without a controller");

    // back pressure only when both stages are full and the output is stalled
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> s1_valid_reg && rsp_valid_reg && !rsp_ready)
        else $error("input stalled while the pipeline has room");

    // an offset is given only for the target it belongs to
    a_offset_target: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.target == cbm_pkg::TGT_RAM || rsp_reg.ram_offset == '0)
                          && (rsp_reg.target == cbm_pkg::TGT_ROM
                              || rsp_reg.rom_offset == '0))
        else $error("offset present for the wrong target");
`endif

endmodule
